@@ hw/rtl/rqz_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rqz_pkg
// Shared types and constants for the int8 affine requantizer pipeline.
// ----------------------------------------------------------------------------
package rqz_pkg;

   localparam int DIV_STEPS   = 10;             // overflow bit plus 9 quotient bits
   localparam int LATENCY     = DIV_STEPS + 3;  // front, divider, two back stages
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int SCALE_W     = 32;
   localparam int SHIFT_W     = 5;
   localparam int SAMPLE_W    = 8;
   localparam int DIVR_W      = SCALE_W + 3;    // scale * 8
   localparam int PART_W      = DIVR_W + 1;
   localparam int LOW_W       = 9;
   localparam int QUO_W       = DIV_STEPS;
   localparam int PROD_W      = SCALE_W + SAMPLE_W;
   localparam int MAG_W       = 9;

   localparam logic DIR_Q4_TO_INT8 = 1'b0;
   localparam logic DIR_INT8_TO_Q4 = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IN_SCALE_NUM,
      CSR_IN_SCALE_SHIFT,
      CSR_IN_ZERO_POINT,
      CSR_OUT_SCALE_NUM,
      CSR_OUT_SCALE_SHIFT,
      CSR_OUT_ZERO_POINT
   } csr_index_type;

   typedef struct packed {
      logic [SCALE_W-1:0]         in_scale_num;
      logic [SHIFT_W-1:0]         in_scale_shift;
      logic signed [SAMPLE_W-1:0] in_zero_point;
      logic [SCALE_W-1:0]         out_scale_num;
      logic [SHIFT_W-1:0]         out_scale_shift;
      logic signed [SAMPLE_W-1:0] out_zero_point;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic              dir;
      logic              neg;
      logic              bad;
      logic [PART_W-1:0] part;
      logic [LOW_W-1:0]  low;
      logic [QUO_W-1:0]  quo;
      logic [PROD_W-1:0] prod;
   } stage_type;

endpackage
`default_nettype wire

@@ hw/rtl/rqz_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rqz_front
// Entry stage: sign/magnitude split, dividend alignment and scale product.
// ----------------------------------------------------------------------------
module rqz_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic                             req_type,
   input  wire logic signed [rqz_pkg::SAMPLE_W-1:0] req_sample_in,
   input  wire rqz_pkg::cfg_type                 cfg,
   output rqz_pkg::stage_type                    stage_out
);

   rqz_pkg::stage_type stage_ff;
   rqz_pkg::stage_type stage_in;

   logic [7:0]  mag0;
   logic [7:0]  mag1;
   logic [7:0]  mag;
   logic signed [8:0] centered;
   logic signed [8:0] centered_neg;
   logic [38:0] aligned;

   always_comb begin
      mag0         = req_sample_in[7] ? 8'(~req_sample_in + 8'sd1) : 8'(req_sample_in);
      centered     = {req_sample_in[7], req_sample_in} - {cfg.out_zero_point[7], cfg.out_zero_point};
      centered_neg = -centered;
      mag1         = centered[8] ? centered_neg[7:0] : centered[7:0];
      mag          = (req_type == rqz_pkg::DIR_INT8_TO_Q4) ? mag1 : mag0;
      aligned      = 39'(mag0) << cfg.in_scale_shift;

      stage_in.valid = accept;
      stage_in.dir   = req_type;
      stage_in.quo   = '0;
      stage_in.part  = rqz_pkg::PART_W'(aligned[38:9]);
      stage_in.low   = aligned[8:0];
      stage_in.prod  = rqz_pkg::PROD_W'(mag) * rqz_pkg::PROD_W'(cfg.out_scale_num);
      if (req_type == rqz_pkg::DIR_INT8_TO_Q4) begin
         stage_in.neg = centered[8];
         stage_in.bad = (cfg.out_scale_num == '0);
      end else begin
         stage_in.neg = req_sample_in[7];
         stage_in.bad = (cfg.in_scale_num == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

@@ hw/rtl/rqz_div_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rqz_div_step
// One restoring division step: compare/subtract, shift in next dividend bit.
// ----------------------------------------------------------------------------
module rqz_div_step (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rqz_pkg::stage_type            stage_in,
   input  wire logic [rqz_pkg::DIVR_W-1:0]    divisor,
   output rqz_pkg::stage_type                 stage_out
);

   rqz_pkg::stage_type stage_ff;
   rqz_pkg::stage_type stage_nx_in;

   logic [rqz_pkg::PART_W:0]    diff;
   logic                        ge;
   logic [rqz_pkg::DIVR_W-1:0]  rem;

   always_comb begin
      diff = {1'b0, stage_in.part} - {2'b00, divisor};
      ge   = ~diff[rqz_pkg::PART_W];
      rem  = ge ? diff[rqz_pkg::DIVR_W-1:0] : stage_in.part[rqz_pkg::DIVR_W-1:0];

      stage_nx_in      = stage_in;
      stage_nx_in.part = {rem, stage_in.low[rqz_pkg::LOW_W-1]};
      stage_nx_in.low  = {stage_in.low[rqz_pkg::LOW_W-2:0], 1'b0};
      stage_nx_in.quo  = {stage_in.quo[rqz_pkg::QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_nx_in;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

@@ hw/rtl/rqz_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rqz_back
// Rounding, zero point, saturation and result register.
// ----------------------------------------------------------------------------
module rqz_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rqz_pkg::stage_type                stage_in,
   input  wire rqz_pkg::cfg_type                  cfg,
   output logic                                   rsp_valid,
   output logic signed [rqz_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   output logic                                   rsp_bad_scale
);

   typedef struct packed {
      logic                      valid;
      logic                      dir;
      logic                      neg;
      logic                      bad;
      logic                      big;
      logic [rqz_pkg::MAG_W-1:0] mag;
   } round_type;

   round_type round_ff;
   round_type round_in;

   logic [9:0]  q2_inc;
   logic [44:0] half;
   logic [44:0] sum;
   logic [44:0] scaled;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic signed [7:0]          rsp_sample_ff;
   logic signed [7:0]          rsp_sample_in;
   logic                       rsp_bad_ff;
   logic                       rsp_bad_in;
   logic signed [10:0]         mag_ext;
   logic signed [10:0]         signed_mag;
   logic signed [10:0]         zp_ext;
   logic signed [10:0]         total;

   always_comb begin
      q2_inc = {1'b0, stage_in.quo[8:0]} + 10'd1;
      half   = (cfg.out_scale_shift == '0) ? 45'd0
             : (45'd1 << (cfg.out_scale_shift - 5'd1));
      sum    = {1'b0, stage_in.prod, 4'b0000} + half;
      scaled = sum >> cfg.out_scale_shift;

      round_in.valid = stage_in.valid;
      round_in.dir   = stage_in.dir;
      round_in.neg   = stage_in.neg;
      round_in.bad   = stage_in.bad;
      if (stage_in.dir == rqz_pkg::DIR_INT8_TO_Q4) begin
         round_in.big = |scaled[44:7];
         round_in.mag = {2'b00, scaled[6:0]};
      end else begin
         round_in.big = stage_in.quo[rqz_pkg::QUO_W-1];
         round_in.mag = q2_inc[9:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff.valid <= 1'b0;
      end else begin
         round_ff <= round_in;
      end
   end

   always_comb begin
      mag_ext    = {2'b00, round_ff.mag};
      signed_mag = round_ff.neg ? -mag_ext : mag_ext;
      zp_ext     = (round_ff.dir == rqz_pkg::DIR_Q4_TO_INT8)
                 ? {{3{cfg.in_zero_point[7]}}, cfg.in_zero_point} : 11'sd0;
      total      = signed_mag + zp_ext;

      rsp_valid_in = round_ff.valid;
      rsp_bad_in   = round_ff.bad;
      priority if (round_ff.bad) begin
         rsp_sample_in = 8'sd0;
      end else if (round_ff.big) begin
         rsp_sample_in = round_ff.neg ? -8'sd128 : 8'sd127;
      end else if (total > 11'sd127) begin
         rsp_sample_in = 8'sd127;
      end else if (total < -11'sd128) begin
         rsp_sample_in = -8'sd128;
      end else begin
         rsp_sample_in = total[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_bad_scale  = rsp_bad_ff;

endmodule
`default_nettype wire

@@ hw/rtl/int8_affine_requantizer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// int8_affine_requantizer_core
// Q4 <-> int8 affine requantizer with per-direction scale, shift, zero point.
// ----------------------------------------------------------------------------
// A start transfer reaches the rsp_valid strobe through the entry stage,
// 10 restoring divider stages, the round stage and the output register.
// Throughput: one transfer per cycle; busy is low except during reset.
// Reset: synchronous; clears the pipeline valid bits and loads the register
// defaults (scales 1, shifts 0, zero points 0). csr_ready is always high.
module int8_affine_requantizer_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic                                  req_type,
   input  wire logic signed [rqz_pkg::SAMPLE_W-1:0]   req_sample_in,
   output logic                                       rsp_valid,
   output logic signed [rqz_pkg::SAMPLE_W-1:0]        rsp_sample_out,
   output logic                                       rsp_bad_scale,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [rqz_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [rqz_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   rqz_pkg::cfg_type   cfg_ff;
   rqz_pkg::stage_type div_stage [0:rqz_pkg::DIV_STEPS];
   logic [rqz_pkg::DIVR_W-1:0] divisor;
   logic accept;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;
   assign divisor   = {cfg_ff.in_scale_num, 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_scale_num    <= rqz_pkg::SCALE_W'(1);
         cfg_ff.in_scale_shift  <= '0;
         cfg_ff.in_zero_point   <= '0;
         cfg_ff.out_scale_num   <= rqz_pkg::SCALE_W'(1);
         cfg_ff.out_scale_shift <= '0;
         cfg_ff.out_zero_point  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (rqz_pkg::csr_index_type'(csr_index))
            rqz_pkg::CSR_IN_SCALE_NUM: begin
               cfg_ff.in_scale_num <= csr_wdata[rqz_pkg::SCALE_W-1:0];
            end
            rqz_pkg::CSR_IN_SCALE_SHIFT: begin
               cfg_ff.in_scale_shift <= csr_wdata[rqz_pkg::SHIFT_W-1:0];
            end
            rqz_pkg::CSR_IN_ZERO_POINT: begin
               cfg_ff.in_zero_point <= csr_wdata[rqz_pkg::SAMPLE_W-1:0];
            end
            rqz_pkg::CSR_OUT_SCALE_NUM: begin
               cfg_ff.out_scale_num <= csr_wdata[rqz_pkg::SCALE_W-1:0];
            end
            rqz_pkg::CSR_OUT_SCALE_SHIFT: begin
               cfg_ff.out_scale_shift <= csr_wdata[rqz_pkg::SHIFT_W-1:0];
            end
            rqz_pkg::CSR_OUT_ZERO_POINT: begin
               cfg_ff.out_zero_point <= csr_wdata[rqz_pkg::SAMPLE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   rqz_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_type      (req_type),
      .req_sample_in (req_sample_in),
      .cfg           (cfg_ff),
      .stage_out     (div_stage[0])
   );

   for (genvar k = 0; k < rqz_pkg::DIV_STEPS; k++) begin : g_div
      rqz_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (div_stage[k]),
         .divisor   (divisor),
         .stage_out (div_stage[k+1])
      );
   end

   rqz_back u_back (
      .clock          (clock),
      .reset          (reset),
      .stage_in       (div_stage[rqz_pkg::DIV_STEPS]),
      .cfg            (cfg_ff),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out),
      .rsp_bad_scale  (rsp_bad_scale)
   );

endmodule
`default_nettype wire

@@ hw/rtl/rqz_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rqz_checker
// Port-level checks on result timing and error reporting.
// ----------------------------------------------------------------------------
module rqz_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic                                rsp_valid,
   input wire logic signed [rqz_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input wire logic                                rsp_bad_scale
);

   // every transfer yields one strobe after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(rqz_pkg::LATENCY) rsp_valid)
      else $error("missing result strobe");

   // no strobe without a matching transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, rqz_pkg::LATENCY))
      else $error("result strobe without transfer");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_scale) |-> (rsp_sample_out == 8'sd0))
      else $error("nonzero result with bad scale");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind int8_affine_requantizer_core rqz_checker u_checker (.*);
`default_nettype wire

@@ test/int8_affine_requantizer_core_test.sv @@
// ----------------------------------------------------------------------------
// int8_affine_requantizer_core_test
// Self-checking bench for the requantizer core. A short table of directed
// conversions and register writes comes first. Randomized register settings
// follow, each carrying a run of random conversions sent in bursts. Typed
// directed rows carry fixed expected results; every other response is checked
// against a local model of the rounding, zero point and saturation rules.
// ----------------------------------------------------------------------------
module int8_affine_requantizer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [rqz_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [rqz_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int DIRECTED_ROWS   = 37;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 123;
   localparam int DRAIN_LIMIT     = 2000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic signed [rqz_pkg::SAMPLE_W-1:0] sample_out;
      logic                                bad_scale;
   } conversion_type;

   typedef struct packed {
      logic                                is_csr;
      logic [rqz_pkg::CSR_INDEX_W-1:0]     index;
      logic [rqz_pkg::CSR_DATA_W-1:0]      wdata;
      logic                                dir;
      logic signed [rqz_pkg::SAMPLE_W-1:0] sample;
      logic                                typed;
      conversion_type                      expected;
   } plan_row_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic                                req_type;
   logic signed [rqz_pkg::SAMPLE_W-1:0] req_sample_in;
   logic                                rsp_valid;
   logic signed [rqz_pkg::SAMPLE_W-1:0] rsp_sample_out;
   logic                                rsp_bad_scale;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [rqz_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [rqz_pkg::CSR_DATA_W-1:0]      csr_wdata;

   rqz_pkg::cfg_type model_cfg;
   conversion_type   pending_conversions[$];
   plan_row_type     directed_plan[DIRECTED_ROWS];
   bit               sending;
   int               error_count;
   int               conversions_sent;
   int               responses_checked;
   int               bad_scale_seen;
   int               settings_applied;

   int8_affine_requantizer_core DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out),
      .rsp_bad_scale  (rsp_bad_scale),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d conversions still pending", pending_conversions.size());
      $display("*** FAILED ***");
      $finish;
   end

   function automatic conversion_type predict_requant(
      logic dir, logic signed [rqz_pkg::SAMPLE_W-1:0] x);
      conversion_type res;
      logic [63:0] mag;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] quo;
      logic [63:0] rem;
      int          centered;
      int          capped;
      int          value;
      bit          neg;
      res.sample_out = '0;
      res.bad_scale  = 1'b0;
      if (dir == rqz_pkg::DIR_Q4_TO_INT8) begin
         if (model_cfg.in_scale_num == '0) begin
            res.bad_scale = 1'b1;
            return res;
         end
         centered = int'(x);
      end else begin
         if (model_cfg.out_scale_num == '0) begin
            res.bad_scale = 1'b1;
            return res;
         end
         centered = int'(x) - int'($signed(model_cfg.out_zero_point));
      end
      neg = centered < 0;
      mag = 64'(neg ? -centered : centered);
      if (dir == rqz_pkg::DIR_Q4_TO_INT8) begin
         num = mag << model_cfg.in_scale_shift;
         den = 64'(model_cfg.in_scale_num) * 64'd16;
      end else begin
         num = mag * 64'(model_cfg.out_scale_num) * 64'd16;
         den = 64'd1 << model_cfg.out_scale_shift;
      end
      quo = num / den;
      rem = num % den;
      if (rem >= (den + 64'd1) / 64'd2) quo = quo + 64'd1;
      capped = (quo > 64'd1024) ? 1024 : int'(quo);
      value  = neg ? -capped : capped;
      if (dir == rqz_pkg::DIR_Q4_TO_INT8)
         value = value + int'($signed(model_cfg.in_zero_point));
      if (value > 127) value = 127;
      if (value < -128) value = -128;
      res.sample_out = rqz_pkg::SAMPLE_W'(value);
      return res;
   endfunction

   function automatic void apply_csr(logic [rqz_pkg::CSR_INDEX_W-1:0] idx,
                                     logic [rqz_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         rqz_pkg::CSR_IN_SCALE_NUM:
            model_cfg.in_scale_num    = data;
         rqz_pkg::CSR_IN_SCALE_SHIFT:
            model_cfg.in_scale_shift  = data[rqz_pkg::SHIFT_W-1:0];
         rqz_pkg::CSR_IN_ZERO_POINT:
            model_cfg.in_zero_point   = data[rqz_pkg::SAMPLE_W-1:0];
         rqz_pkg::CSR_OUT_SCALE_NUM:
            model_cfg.out_scale_num   = data;
         rqz_pkg::CSR_OUT_SCALE_SHIFT:
            model_cfg.out_scale_shift = data[rqz_pkg::SHIFT_W-1:0];
         rqz_pkg::CSR_OUT_ZERO_POINT:
            model_cfg.out_zero_point  = data[rqz_pkg::SAMPLE_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic plan_row_type csr_row(logic [rqz_pkg::CSR_INDEX_W-1:0] idx,
                                            logic [rqz_pkg::CSR_DATA_W-1:0] data);
      plan_row_type row;
      row        = '0;
      row.is_csr = 1'b1;
      row.index  = idx;
      row.wdata  = data;
      return row;
   endfunction

   function automatic plan_row_type item_row(logic dir,
                                             logic signed [rqz_pkg::SAMPLE_W-1:0] x);
      plan_row_type row;
      row        = '0;
      row.dir    = dir;
      row.sample = x;
      return row;
   endfunction

   function automatic plan_row_type typed_row(logic dir,
                                              logic signed [rqz_pkg::SAMPLE_W-1:0] x,
                                              logic signed [rqz_pkg::SAMPLE_W-1:0] res,
                                              logic bad);
      plan_row_type row;
      row                     = item_row(dir, x);
      row.typed               = 1'b1;
      row.expected.sample_out = res;
      row.expected.bad_scale  = bad;
      return row;
   endfunction

   // scale near 2^(shift-4-k) keeps most results off the rails
   function automatic logic [rqz_pkg::SCALE_W-1:0] pick_scale(int shift);
      int                          e;
      logic [rqz_pkg::SCALE_W-1:0] s;
      case ($urandom_range(0, 9))
         0: s = '0;
         1: s = '1;
         2: s = 32'd1;
         3, 4: s = $urandom;
         default: begin
            e = shift - 4 - int'($urandom_range(0, 7));
            if (e < 0) e = 0;
            s = (32'($urandom) | 32'h8000_0000) >> (31 - e);
         end
      endcase
      return s;
   endfunction

   function automatic logic signed [rqz_pkg::SAMPLE_W-1:0] pick_sample();
      logic signed [rqz_pkg::SAMPLE_W-1:0] x;
      case ($urandom_range(0, 7))
         0: x = 8'sh80;
         1: x = 8'sh7F;
         2: x = 8'($urandom_range(0, 8)) - 8'd4;
         default: x = 8'($urandom);
      endcase
      return x;
   endfunction

   task automatic issue(logic dir, logic signed [rqz_pkg::SAMPLE_W-1:0] x, bit typed,
                        conversion_type typed_exp);
      start         <= 1'b1;
      req_type      <= dir;
      req_sample_in <= x;
      sending = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pending_conversions.push_back(typed ? typed_exp : predict_requant(dir, x));
      conversions_sent++;
   endtask

   task automatic pause(int cycles);
      if (sending) start <= 1'b0;
      sending = 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      if (sending) start <= 1'b0;
      sending = 1'b0;
      while (pending_conversions.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic csr_write(logic [rqz_pkg::CSR_INDEX_W-1:0] idx,
                            logic [rqz_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_csr(idx, data);
   endtask

   always @(posedge clock) begin
      conversion_type exp;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (pending_conversions.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected response: sample_out=%0d bad_scale=%0b",
                        rsp_sample_out, rsp_bad_scale);
         end else begin
            exp = pending_conversions.pop_front();
            responses_checked++;
            if (rsp_bad_scale === 1'b1) bad_scale_seen++;
            if (rsp_sample_out !== exp.sample_out || rsp_bad_scale !== exp.bad_scale) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display({"mismatch on response %0d: sample_out exp %0d got %0d, ",
                            "bad_scale exp %0b got %0b"},
                           responses_checked, exp.sample_out, rsp_sample_out,
                           exp.bad_scale, rsp_bad_scale);
            end
         end
      end
   end

   initial begin
      plan_row_type row;
      bit           in_csr_group;
      bit           steady;
      int           burst_left;
      int           gap;
      int           shift;
      reset         = 1'b1;
      start         = 1'b0;
      req_type      = rqz_pkg::DIR_Q4_TO_INT8;
      req_sample_in = '0;
      csr_valid     = 1'b0;
      csr_index     = rqz_pkg::CSR_IN_SCALE_NUM;
      csr_wdata     = '0;
      sending       = 1'b0;
      error_count   = 0;
      conversions_sent  = 0;
      responses_checked = 0;
      bad_scale_seen    = 0;
      settings_applied  = 1;
      model_cfg                 = '0;
      model_cfg.in_scale_num    = 32'd1;
      model_cfg.out_scale_num   = 32'd1;

      directed_plan = '{
         typed_row(rqz_pkg::DIR_Q4_TO_INT8, 8'sh7F, 8'sd8, 1'b0),
         typed_row(rqz_pkg::DIR_Q4_TO_INT8, 8'sh80, -8'sd8, 1'b0),
         typed_row(rqz_pkg::DIR_Q4_TO_INT8, 8'sd8, 8'sd1, 1'b0),   // half rounds away from zero
         typed_row(rqz_pkg::DIR_Q4_TO_INT8, -8'sd8, -8'sd1, 1'b0),
         typed_row(rqz_pkg::DIR_Q4_TO_INT8, 8'sd7, 8'sd0, 1'b0),
         typed_row(rqz_pkg::DIR_INT8_TO_Q4, 8'sh7F, 8'sh7F, 1'b0),
         typed_row(rqz_pkg::DIR_INT8_TO_Q4, 8'sh80, 8'sh80, 1'b0),
         typed_row(rqz_pkg::DIR_INT8_TO_Q4, 8'sd0, 8'sd0, 1'b0),
         csr_row(rqz_pkg::CSR_IN_SCALE_NUM, 32'd0),
         typed_row(rqz_pkg::DIR_Q4_TO_INT8, 8'sd5, 8'sd0, 1'b1),
         csr_row(rqz_pkg::CSR_OUT_SCALE_NUM, 32'd0),
         typed_row(rqz_pkg::DIR_INT8_TO_Q4, -8'sd3, 8'sd0, 1'b1),
         csr_row(rqz_pkg::CSR_IN_SCALE_NUM, 32'hFFFF_FFFF),
         csr_row(rqz_pkg::CSR_IN_SCALE_SHIFT, 32'hFFFF_FFFF),
         csr_row(rqz_pkg::CSR_IN_ZERO_POINT, 32'hABCD_EF7F),
         item_row(rqz_pkg::DIR_Q4_TO_INT8, 8'sh80),
         item_row(rqz_pkg::DIR_Q4_TO_INT8, 8'sh7F),
         csr_row(rqz_pkg::CSR_OUT_SCALE_NUM, 32'hFFFF_FFFF),
         csr_row(rqz_pkg::CSR_OUT_SCALE_SHIFT, 32'h0000_001F),
         csr_row(rqz_pkg::CSR_OUT_ZERO_POINT, 32'h1234_5680),
         item_row(rqz_pkg::DIR_INT8_TO_Q4, 8'sh7F),
         item_row(rqz_pkg::DIR_INT8_TO_Q4, 8'sh80),
         csr_row(CSR_SPARE_LO, 32'h0000_0000),
         csr_row(CSR_SPARE_HI, 32'hFFFF_FFFF),
         item_row(rqz_pkg::DIR_Q4_TO_INT8, 8'sd64),
         item_row(rqz_pkg::DIR_INT8_TO_Q4, -8'sd1),
         csr_row(rqz_pkg::CSR_OUT_SCALE_NUM, 32'd1),
         csr_row(rqz_pkg::CSR_OUT_SCALE_SHIFT, 32'd5),
         csr_row(rqz_pkg::CSR_OUT_ZERO_POINT, 32'd0),
         typed_row(rqz_pkg::DIR_INT8_TO_Q4, 8'sd1, 8'sd1, 1'b0),
         typed_row(rqz_pkg::DIR_INT8_TO_Q4, -8'sd1, -8'sd1, 1'b0),
         typed_row(rqz_pkg::DIR_INT8_TO_Q4, 8'sh80, -8'sd64, 1'b0),
         csr_row(rqz_pkg::CSR_IN_SCALE_NUM, 32'd1),
         csr_row(rqz_pkg::CSR_IN_SCALE_SHIFT, 32'd0),
         csr_row(rqz_pkg::CSR_IN_ZERO_POINT, 32'h0000_0080),
         typed_row(rqz_pkg::DIR_Q4_TO_INT8, 8'sh80, 8'sh80, 1'b0),
         typed_row(rqz_pkg::DIR_Q4_TO_INT8, 8'sh7F, -8'sd120, 1'b0)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      in_csr_group = 1'b0;
      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.is_csr) begin
            if (!in_csr_group) begin
               drain_results();
               settings_applied++;
            end
            csr_write(row.index, row.wdata);
            in_csr_group = 1'b1;
         end else begin
            if (in_csr_group) csr_valid <= 1'b0;
            in_csr_group = 1'b0;
            issue(row.dir, row.sample, row.typed, row.expected);
         end
      end
      if (in_csr_group) csr_valid <= 1'b0;

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         settings_applied++;
         if (phase == 0 || $urandom_range(0, 3) != 0) begin
            shift = $urandom_range(0, 31);
            csr_write(rqz_pkg::CSR_IN_SCALE_SHIFT, {27'($urandom), 5'(shift)});
         end
         if (phase == 0 || $urandom_range(0, 3) != 0)
            csr_write(rqz_pkg::CSR_IN_SCALE_NUM,
                      pick_scale(int'(model_cfg.in_scale_shift)));
         if (phase == 0 || $urandom_range(0, 3) != 0)
            csr_write(rqz_pkg::CSR_IN_ZERO_POINT, $urandom);
         if (phase == 0 || $urandom_range(0, 3) != 0) begin
            shift = $urandom_range(0, 31);
            csr_write(rqz_pkg::CSR_OUT_SCALE_SHIFT, {27'($urandom), 5'(shift)});
         end
         if (phase == 0 || $urandom_range(0, 3) != 0)
            csr_write(rqz_pkg::CSR_OUT_SCALE_NUM,
                      pick_scale(int'(model_cfg.out_scale_shift)));
         if (phase == 0 || $urandom_range(0, 3) != 0)
            csr_write(rqz_pkg::CSR_OUT_ZERO_POINT, $urandom);
         if ($urandom_range(0, 3) == 0)
            csr_write($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
         csr_valid <= 1'b0;

         steady     = ($urandom_range(0, 3) == 0);
         burst_left = $urandom_range(1, 24);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            issue(1'($urandom_range(0, 1)), pick_sample(), 1'b0, '0);
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if (!steady) begin
                  gap = $urandom_range(0, 9);
                  if (gap > 0) pause(gap);
               end
            end
         end
      end

      drain_results();
      repeat (rqz_pkg::LATENCY + 4) @(posedge clock);
      if (pending_conversions.size() != 0) begin
         $display("%0d conversions never returned", pending_conversions.size());
         error_count += pending_conversions.size();
      end

      $display("sent %0d conversions over %0d register settings, %0d responses checked",
               conversions_sent, settings_applied, responses_checked);
      $display("%0d responses flagged a zero scale, %0d failures", bad_scale_seen, error_count);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
